@@ rtl/core/b64d_pkg.sv @@
`default_nettype none

package b64d_pkg;

   localparam logic [7:0] PAD_CODE = 8'h3D;

   // One classified character as it travels from the front stage to the decoder.
   typedef struct packed {
      logic [5:0] sextet;    // alphabet value, zero for padding or bad codes
      logic       pad;       // character is '='
      logic       bad_char;  // character is neither in the alphabet nor '='
      logic       last_char; // final character of the message
   } item_type;

   localparam int ITEM_W = $bits(item_type);

   // Map one character code onto the standard alphabet.
   function automatic item_type classify(input logic [7:0] code, input logic last);
      item_type   res;
      logic [7:0] val;
      res = '0;
      val = 8'h00;
      res.last_char = last;
      if (code >= 8'h41 && code <= 8'h5A) begin
         val = code - 8'h41;
      end else if (code >= 8'h61 && code <= 8'h7A) begin
         val = code - 8'h47;
      end else if (code >= 8'h30 && code <= 8'h39) begin
         val = code + 8'h04;
      end else if (code == 8'h2B) begin
         val = 8'd62;
      end else if (code == 8'h2F) begin
         val = 8'd63;
      end else if (code == PAD_CODE) begin
         res.pad = 1'b1;
      end else begin
         res.bad_char = 1'b1;
      end
      res.sextet = val[5:0];
      return res;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/b64d_front.sv @@
`default_nettype none

module b64d_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        req_char_code,
   input  wire logic              req_last_char,
   output logic                   item_valid,
   input  wire logic              item_stall,
   output b64d_pkg::item_type     item_data
);

   logic               valid_ff, valid_in;
   b64d_pkg::item_type data_ff;
   logic               load;

   assign req_stall = valid_ff && item_stall;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !item_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Classify on the way in; hold while stalled.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= b64d_pkg::classify(req_char_code, req_last_char);
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

`default_nettype wire

@@ rtl/core/b64d_queue.sv @@
`default_nettype none

module b64d_queue #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_stall,
   input  wire b64d_pkg::item_type in_data,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output b64d_pkg::item_type     out_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   b64d_pkg::item_type slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign in_stall  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/b64d_back.sv @@
`default_nettype none

module b64d_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   output logic                   item_stall,
   input  wire b64d_pkg::item_type item_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_byte_valid,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_bad_input,
   output logic                   rsp_end_of_message
);

   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;
   localparam logic [1:0] PHASE_FOURTH = 2'd3;

   logic [1:0] phase_ff, phase_in;
   logic [5:0] held_ff, held_in;
   logic       error_ff, error_in;
   logic       out_valid_ff, out_valid_in;
   logic       byte_valid_ff, byte_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bad_ff;
   logic       eom_ff;
   logic       take;
   logic [1:0] phase_next;
   logic [5:0] held_next;
   logic       error_next;

   assign item_stall = out_valid_ff && rsp_stall;
   assign take       = item_valid && !item_stall;

   always_comb begin
      phase_next    = phase_ff;
      held_next     = held_ff;
      error_next    = error_ff;
      byte_valid_in = 1'b0;
      byte_in       = 8'h00;
      if (!error_ff) begin
         if (item_data.bad_char) begin
            error_next = 1'b1;
         end else if (item_data.pad &&
                      (phase_ff == PHASE_FIRST || phase_ff == PHASE_SECOND)) begin
            error_next = 1'b1;
         end else begin
            unique case (phase_ff)
               PHASE_FIRST: begin
               end
               PHASE_SECOND: begin
                  byte_valid_in = 1'b1;
                  byte_in       = {held_ff, item_data.sextet[5:4]};
               end
               PHASE_THIRD: begin
                  byte_valid_in = !item_data.pad;
                  byte_in       = {held_ff[3:0], item_data.sextet[5:2]};
               end
               PHASE_FOURTH: begin
                  byte_valid_in = !item_data.pad;
                  byte_in       = {held_ff[1:0], item_data.sextet};
               end
               default: begin
               end
            endcase
            held_next  = item_data.sextet;
            phase_next = phase_ff + 1'b1;
         end
      end
      // Flag a short last group.
      if (item_data.last_char && phase_next != PHASE_FIRST) begin
         error_next = 1'b1;
      end
      if (!byte_valid_in) begin
         byte_in = 8'h00;
      end
      // Drop all message state after the last character.
      phase_in = item_data.last_char ? PHASE_FIRST : phase_next;
      held_in  = item_data.last_char ? 6'd0 : held_next;
      error_in = item_data.last_char ? 1'b0 : error_next;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_FIRST;
         held_ff      <= 6'd0;
         error_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            phase_ff <= phase_in;
            held_ff  <= held_in;
            error_ff <= error_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_valid_ff <= byte_valid_in;
         byte_ff       <= byte_in;
         bad_ff        <= error_next;
         eom_ff        <= item_data.last_char;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_byte_valid     = byte_valid_ff;
   assign rsp_out_byte       = byte_ff;
   assign rsp_bad_input      = bad_ff;
   assign rsp_end_of_message = eom_ff;

endmodule

`default_nettype wire

@@ rtl/core/base64_stream_decoder_unit.sv @@
`default_nettype none

// Channel    Direction  Handshake             Payload
// request    in         req_valid/req_stall   req_char_code[7:0], req_last_char
// response   out        rsp_valid/rsp_stall   rsp_byte_valid, rsp_out_byte[7:0],
//                                             rsp_bad_input, rsp_end_of_message
//
// One request in and one response out per cycle when neither side stalls.
// Each item passes the front register, a queue slot and the response register.
// The decode state (phase, held sextet, error latch) updates once per
// request taken in the back stage.
// Synchronous active-high reset empties every stage and starts a new group.
// A stalled response holds the back stage; the queue keeps taking requests
// until full, and only then does req_stall rise.

module base64_stream_decoder_unit #(
   parameter int QUEUE_DEPTH = 2   // queue slots between classify and decode, 2 or more
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_last_char,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_byte_valid,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_bad_input,
   output logic            rsp_end_of_message
);

   // Front to queue: classified character.
   logic               front_valid;
   logic               front_stall;
   b64d_pkg::item_type front_data;

   // Queue to decoder.
   logic               queue_valid;
   logic               queue_stall;
   b64d_pkg::item_type queue_data;

   // Register each request and map it onto the alphabet.
   b64d_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .item_valid    (front_valid),
      .item_stall    (front_stall),
      .item_data     (front_data)
   );

   // Decouple classification from the decode state so each side stalls alone.
   b64d_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_data   (front_data),
      .out_valid (queue_valid),
      .out_stall (queue_stall),
      .out_data  (queue_data)
   );

   // Advance group phase, build bytes, track errors, register the response.
   b64d_back u_back (
      .clock              (clock),
      .reset              (reset),
      .item_valid         (queue_valid),
      .item_stall         (queue_stall),
      .item_data          (queue_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_bad_input      (rsp_bad_input),
      .rsp_end_of_message (rsp_end_of_message)
   );

endmodule

`default_nettype wire
